[rtl/core/slins_pkg.sv]
// ----------------------------------------------------------------------------
// slins_pkg: shared types and constants for the sequential list insert block
// Sizes of the list, field widths, status and operation codes, control states.
// ----------------------------------------------------------------------------
package slins_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int GRP_SIZE = 16;
    localparam int N_GRP    = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_READ   = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GATHER,
        S_FINISH
    } t_state;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic              ins_en;
        logic              tap_en;
        logic              rd_ok;
        logic [POS_W-1:0]  slot;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

[rtl/core/sequential_list_insert_top.sv]
// ----------------------------------------------------------------------------
// sequential_list_insert_top: ordered list with insert and read at position
// Keeps up to CAPACITY signed entries in a row of cells plus the list length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries kind, value and a 1-based
//   position. Output channel (o_out_valid / i_out_stall) returns status,
//   read value and list length after the transaction; one result per input.
//   The block holds one transaction at a time; o_in_stall is high while it
//   is busy.
//   Insert: all cells compare their index with the position and shift in
//   parallel, and the result is registered once the result slot is free.
//   Read: the selected cell taps its entry, a two-level OR tree with a
//   registered group level gathers it, and the result is then registered.
//   The block takes no new transaction until the current one has finished,
//   as set by the control sequencer and the read gather tree.
//   Reset clears the length, the control state and the output valid; entries
//   need no clearing since only positions 1..length are ever read.
//   While the receiver stalls, the result register holds and the block
//   waits before finishing its next transaction.
// ----------------------------------------------------------------------------
module sequential_list_insert_top import slins_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [LEN_W-1:0]         o_list_length
);

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_count, n_count;
    t_kind             r_kind;
    logic [DATA_W-1:0] r_value;
    logic [POS_W-1:0]  r_pos;
    t_status           r_status;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_data;
    logic [LEN_W-1:0]  r_out_len;

    t_cell_cmd         cell_cmd;
    logic              grp_en;
    logic              out_free;
    logic              out_load;
    t_status           out_status;
    logic [DATA_W-1:0] out_data;
    logic              in_accept;
    logic              ins_pos_ok;
    logic              rd_ok;
    logic              full;
    t_status           ins_status;
    t_status           rd_status;
    logic [DATA_W-1:0] tree_data;

    logic [DATA_W-1:0] entries [CAPACITY];
    logic [DATA_W-1:0] taps [CAPACITY];

    assign o_in_stall = r_state != S_IDLE;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign full       = r_count == LEN_W'(CAPACITY);
    assign ins_pos_ok = (r_pos != '0) &&
                        ({1'b0, r_pos} <= ({1'b0, r_count} + (LEN_W + 1)'(1)));
    assign rd_ok      = (r_pos != '0) && ({1'b0, r_pos} <= {1'b0, r_count});
    assign ins_status = !ins_pos_ok ? ST_BADPOS : (full ? ST_FULL : ST_OK);
    assign rd_status  = rd_ok ? ST_OK : ST_BADPOS;

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        grp_en         = 1'b0;
        out_load       = 1'b0;
        out_status     = ST_OK;
        out_data       = '0;
        cell_cmd.ins_en = 1'b0;
        cell_cmd.tap_en = 1'b0;
        cell_cmd.rd_ok  = rd_ok;
        cell_cmd.slot   = r_pos - POS_W'(1);
        cell_cmd.value  = r_value;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_kind == KIND_INSERT) begin
                    // hold until the result slot is free, then commit
                    if (out_free) begin
                        cell_cmd.ins_en = ins_status == ST_OK;
                        if (ins_status == ST_OK) begin
                            n_count = r_count + LEN_W'(1);
                        end
                        out_load   = 1'b1;
                        out_status = ins_status;
                        n_state    = S_IDLE;
                    end
                end else begin
                    cell_cmd.tap_en = 1'b1;
                    n_state         = S_GATHER;
                end
            end
            S_GATHER: begin
                grp_en  = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = r_status;
                    out_data   = tree_data;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= t_kind'(i_kind);
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (r_state == S_EXEC) begin
            r_status <= rd_status;
        end
        if (out_load) begin
            r_out_status <= out_status;
            r_out_data   <= out_data;
            r_out_len    <= n_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            slins_cell u_cell (
                .i_clk        (i_clk),
                .i_index      (IDX_W'(g)),
                .i_cmd        (cell_cmd),
                .i_prev_entry (r_value),
                .o_entry      (entries[g]),
                .o_tap        (taps[g])
            );
        end else begin : g_rest
            slins_cell u_cell (
                .i_clk        (i_clk),
                .i_index      (IDX_W'(g)),
                .i_cmd        (cell_cmd),
                .i_prev_entry (entries[g-1]),
                .o_entry      (entries[g]),
                .o_tap        (taps[g])
            );
        end
    end

    slins_tree u_tree (
        .i_clk    (i_clk),
        .i_grp_en (grp_en),
        .i_taps   (taps),
        .o_data   (tree_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = r_out_data;
    assign o_list_length = r_out_len;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            r_count == $past(r_count) + LEN_W'(1))
        else $error("list length changed by other than one");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_FULL) |-> r_out_len == LEN_W'(CAPACITY))
        else $error("full status with list not full");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != ST_OK) |-> r_out_data == '0)
        else $error("failed transaction carries nonzero data");

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GATHER) |=> (r_state == S_FINISH) && $stable(r_count))
        else $error("read gather sequence broken");
`endif

endmodule

[rtl/core/slins_cell.sv]
// ----------------------------------------------------------------------------
// slins_cell: one list slot
// Holds one entry, shifts in its lower neighbor on insert, taps for reads.
// ----------------------------------------------------------------------------
module slins_cell import slins_pkg::*; (
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_index,
    input  t_cell_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_prev_entry,
    output logic [DATA_W-1:0] o_entry,
    output logic [DATA_W-1:0] o_tap
);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] r_tap;
    logic [POS_W-1:0]  idx_ext;
    logic              above;
    logic              at;

    assign idx_ext = POS_W'(i_index);
    assign above   = idx_ext > i_cmd.slot;
    assign at      = idx_ext == i_cmd.slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_en) begin
            if (above) begin
                r_entry <= i_prev_entry;
            end else if (at) begin
                r_entry <= i_cmd.value;
            end
        end
        if (i_cmd.tap_en) begin
            r_tap <= (at && i_cmd.rd_ok) ? r_entry : '0;
        end
    end

    assign o_entry = r_entry;
    assign o_tap   = r_tap;

endmodule

[rtl/core/slins_tree.sv]
// ----------------------------------------------------------------------------
// slins_tree: read gather
// ORs the cell taps in registered groups, then merges the groups.
// ----------------------------------------------------------------------------
module slins_tree import slins_pkg::*; (
    input  logic              i_clk,
    input  logic              i_grp_en,
    input  logic [DATA_W-1:0] i_taps [CAPACITY],
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_grp [N_GRP];
    logic [DATA_W-1:0] grp_or [N_GRP];

    always_comb begin
        for (int g = 0; g < N_GRP; g++) begin
            grp_or[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                if (g * GRP_SIZE + k < CAPACITY) begin
                    grp_or[g] = grp_or[g] | i_taps[g * GRP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_en) begin
            for (int g = 0; g < N_GRP; g++) begin
                r_grp[g] <= grp_or[g];
            end
        end
    end

    always_comb begin
        o_data = '0;
        for (int g = 0; g < N_GRP; g++) begin
            o_data = o_data | r_grp[g];
        end
    end

endmodule

[dv/sequential_list_insert_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_insert_checker: result predictor and scoreboard
// Watches both channels of the list block, keeps its own copy of the list,
// predicts the reply to every accepted transaction and compares each
// accepted reply field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module sequential_list_insert_checker import slins_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic                     i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_position,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [1:0]               i_status,
    input  logic signed [DATA_W-1:0] i_read_value,
    input  logic [LEN_W-1:0]         i_list_length,
    output int                       o_error_count,
    output int                       o_pending
);

    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         length;
    } t_list_reply;

    localparam int MAX_LINES = 60;

    logic signed [DATA_W-1:0] list_shadow [CAPACITY];
    int                       list_len;
    t_list_reply              pending_replies [$];
    int                       error_count;

    initial begin
        error_count   = 0;
        list_len      = 0;
        o_error_count = 0;
        o_pending     = 0;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        if (error_count < MAX_LINES) begin
            $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h",
                     $realtime, what, want, got);
        end
        error_count++;
    endtask

    // Insert shifts the tail up by one slot; read taps one entry.
    task automatic apply_list_op(input t_kind op, input logic signed [DATA_W-1:0] val,
                                 input logic [POS_W-1:0] pos, output t_list_reply reply);
        int slot;
        slot = int'(pos);
        reply.status     = ST_OK;
        reply.read_value = '0;
        if (op == KIND_INSERT) begin
            if (slot < 1 || slot > list_len + 1) begin
                reply.status = ST_BADPOS;
            end else if (list_len >= CAPACITY) begin
                reply.status = ST_FULL;
            end else begin
                for (int j = list_len; j >= slot; j--) begin
                    list_shadow[j] = list_shadow[j-1];
                end
                list_shadow[slot-1] = val;
                list_len++;
            end
        end else begin
            if (slot < 1 || slot > list_len) begin
                reply.status = ST_BADPOS;
            end else begin
                reply.read_value = list_shadow[slot-1];
            end
        end
        reply.length = LEN_W'(list_len);
    endtask

    always @(posedge i_clk) begin
        t_list_reply predicted;
        t_list_reply want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                apply_list_op(t_kind'(i_kind), i_value, i_position, predicted);
                pending_replies.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected reply (status)", '0, 32'(i_status));
                end else begin
                    want = pending_replies.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(i_status));
                    if (i_read_value !== want.read_value)
                        report_mismatch("read_value", want.read_value, i_read_value);
                    if (i_list_length !== want.length)
                        report_mismatch("list_length", 32'(want.length), 32'(i_list_length));
                end
            end
        end
        o_error_count <= error_count;
        o_pending     <= pending_replies.size();
    end

endmodule

[dv/sequential_list_insert_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_insert_top_tb: stimulus and verdict for the list block
// Drives directed corner transactions, then random inserts and reads that
// grow the list to full and keep exercising it there, with bursty input
// pacing and a patterned output stall including long hold-offs.
// ----------------------------------------------------------------------------
module sequential_list_insert_top_tb;
    import slins_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 12;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_kind;
    logic signed [DATA_W-1:0] i_value;
    logic [POS_W-1:0]         i_position;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_read_value;
    logic [LEN_W-1:0]         o_list_length;

    int error_count;
    int pending;
    int cycle_count;

    // stimulus-side bookkeeping of the list length and what was offered
    int fill_level;
    int burst_left;
    int n_items;
    int n_inserted;
    int n_full_rejects;
    int n_bad_inserts;
    int n_reads;

    sequential_list_insert_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_list_length (o_list_length)
    );

    sequential_list_insert_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_read_value  (o_read_value),
        .i_list_length (o_list_length),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: alternate stall patterns, with long hold-offs that back up the block.
    initial begin
        int mode;
        int run;
        int holds_done;
        holds_done = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (holds_done < 3 && cycle_count > 800 + holds_done * 4000) begin
                i_out_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
                holds_done++;
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(4, 40);
            for (int c = 0; c < run; c++) begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 1) == 1);
                    2: i_out_stall <= c[0];
                    default: i_out_stall <= (c < 6);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Offer one transaction, hold it until accepted, then pace the next one.
    task automatic send_item(input t_kind op, input logic signed [DATA_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        int slot;
        slot = int'(pos);
        i_in_valid <= 1'b1;
        i_kind     <= op;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        n_items++;
        if (op == KIND_INSERT) begin
            if (slot < 1 || slot > fill_level + 1) begin
                n_bad_inserts++;
            end else if (fill_level >= CAPACITY) begin
                n_full_rejects++;
            end else begin
                fill_level++;
                n_inserted++;
            end
        end else begin
            n_reads++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Grow the list while it has room, then keep hitting it once full.
    task automatic send_random_item();
        int roll;
        int slot;
        t_kind op;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            op = KIND_INSERT;
            case ($urandom_range(0, 3))
                0:       slot = 1;
                1:       slot = fill_level + 1;
                default: slot = $urandom_range(1, fill_level + 1);
            endcase
        end else if (roll < 45) begin
            op = KIND_INSERT;
            case ($urandom_range(0, 2))
                0:       slot = 0;
                1:       slot = fill_level + 2;
                default: slot = $urandom_range(fill_level + 2, 255);
            endcase
        end else if (roll < 88 && fill_level > 0) begin
            op = KIND_READ;
            case ($urandom_range(0, 4))
                0:       slot = 1;
                1:       slot = fill_level;
                default: slot = $urandom_range(1, fill_level);
            endcase
        end else begin
            op = KIND_READ;
            case ($urandom_range(0, 2))
                0:       slot = 0;
                1:       slot = fill_level + 1;
                default: slot = $urandom_range(fill_level + 1, 255);
            endcase
        end
        send_item(op, pick_value(), POS_W'(slot));
    endtask

    initial begin
        cycle_count    = 0;
        fill_level     = 0;
        burst_left     = 0;
        n_items        = 0;
        n_inserted     = 0;
        n_full_rejects = 0;
        n_bad_inserts  = 0;
        n_reads        = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind     <= KIND_INSERT;
        i_value    <= '0;
        i_position <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, bad positions, front/middle/end inserts, extreme values
        send_item(KIND_READ,   $urandom, 8'd1);
        send_item(KIND_READ,   $urandom, 8'd0);
        send_item(KIND_INSERT, 32'sh1234_5678, 8'd0);
        send_item(KIND_INSERT, 32'sh1234_5678, 8'd2);
        send_item(KIND_INSERT, 32'sh7FFF_FFFF, 8'd1);
        send_item(KIND_INSERT, 32'sh8000_0000, 8'd1);
        send_item(KIND_INSERT, -32'sd1, 8'd3);
        send_item(KIND_INSERT, 32'sd0, 8'd2);
        send_item(KIND_INSERT, 32'sh0BAD_F00D, 8'd255);
        send_item(KIND_INSERT, 32'sh0BAD_F00D, 8'd6);
        send_item(KIND_READ,   $urandom, 8'd1);
        send_item(KIND_READ,   $urandom, 8'd2);
        send_item(KIND_READ,   $urandom, 8'd3);
        send_item(KIND_READ,   $urandom, 8'd4);
        send_item(KIND_READ,   $urandom, 8'd5);
        send_item(KIND_READ,   $urandom, 8'd255);
        send_item(KIND_READ,   $urandom, 8'd128);
        send_item(KIND_INSERT, 32'sh5555_5555, 8'd5);
        send_item(KIND_INSERT, 32'shAAAA_AAAA, 8'd3);
        send_item(KIND_READ,   $urandom, 8'd3);
        send_item(KIND_READ,   $urandom, 8'd6);

        repeat (RANDOM_ITEMS) send_random_item();

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions: %0d inserts landed, %0d rejected as full,",
                 n_items, n_inserted, n_full_rejects);
        $display("%0d rejected for position, %0d reads; final length %0d of %0d",
                 n_bad_inserts, n_reads, fill_level, CAPACITY);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
